@@ sv/grb_pkg.sv @@
// grb_pkg: shared types, constants and exponential tables for the Gaussian RBF bank.
// Used by gaussian_rbf_bank; no dependencies.
package grb_pkg;

	localparam int MAX_UNITS = 16;
	localparam int UNIT_W    = $clog2(MAX_UNITS);
	localparam int DATA_W    = 16;

	// argument limit 12.0 in Q.16
	localparam logic [35:0] ARG_LIMIT = 36'(12) << 16;
	localparam logic [24:0] ONE_Q24   = 25'd16777216;
	// reciprocal of six in Q.18
	localparam logic [15:0] RECIP6_Q18 = 16'd43691;

	typedef enum logic [1:0] {
		REG_GAUSSIAN_COUNT = 2'd0,
		REG_CENTER_SPACING = 2'd1,
		REG_INV_TWO_SIGMA  = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_index_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         center_index;
		logic signed [15:0] offset_value;
		logic signed [15:0] sample_value;
	} req_word_t;

	typedef struct packed {
		logic [15:0] activation;
		logic [3:0]  unit_index;
		logic        last_of_run;
	} rsp_word_t;

	// exp(-n), Q0.24; entries past 11 never used
	function automatic logic [24:0] exp_int(input logic [3:0] n);
		logic [24:0] r;
		case (n)
			4'd0:    r = 25'd16777216;
			4'd1:    r = 25'd6171993;
			4'd2:    r = 25'd2270549;
			4'd3:    r = 25'd835288;
			4'd4:    r = 25'd307285;
			4'd5:    r = 25'd113044;
			4'd6:    r = 25'd41587;
			4'd7:    r = 25'd15299;
			4'd8:    r = 25'd5628;
			4'd9:    r = 25'd2070;
			4'd10:   r = 25'd762;
			4'd11:   r = 25'd280;
			default: r = 25'd0;
		endcase
		return r;
	endfunction

	// exp(-j/16), Q0.24
	function automatic logic [24:0] exp_sixteenth(input logic [3:0] j);
		logic [24:0] r;
		case (j)
			4'd0:    r = 25'd16777216;
			4'd1:    r = 25'd15760736;
			4'd2:    r = 25'd14805841;
			4'd3:    r = 25'd13908801;
			4'd4:    r = 25'd13066109;
			4'd5:    r = 25'd12274473;
			4'd6:    r = 25'd11530801;
			4'd7:    r = 25'd10832185;
			4'd8:    r = 25'd10175896;
			4'd9:    r = 25'd9559370;
			4'd10:   r = 25'd8980197;
			4'd11:   r = 25'd8436114;
			4'd12:   r = 25'd7924996;
			4'd13:   r = 25'd7444844;
			4'd14:   r = 25'd6993784;
			default: r = 25'd6570052;
		endcase
		return r;
	endfunction

endpackage

@@ sv/grb_ram.sv @@
// grb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module grb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read that holds when not enabled
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/gaussian_rbf_bank.sv @@
// gaussian_rbf_bank: top level of the Gaussian radial basis unit bank.
// Depends on grb_pkg and grb_ram.
//
// Usage:
//   req channel (req_valid/req_stall/req_data): a load word writes one center
//   offset into the offset RAM; a sample word starts a run of
//   one activation per active unit. req_stall is high while a run is active.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one word per unit, unit 0
//   first, last_of_run set on the final unit.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   only while no run is active.
// Throughput: after a sample is accepted the activations leave the output
// register one word per cycle while rsp_stall is low; req_stall stays high
// until the last word of the run is taken, and no new request word is
// accepted before then. The rate is set by the 8-stage read/evaluate
// pipeline behind the offset RAM, one unit a cycle.
// A stalled receiver freezes the whole pipeline and RAM read port.
// Reset clears the configuration to 16 units, spacing 1.0, k 0.5 and marks
// every offset entry invalid so it reads as zero until loaded.
module gaussian_rbf_bank (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  grb_pkg::req_word_t  req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output grb_pkg::rsp_word_t  rsp_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int UW = grb_pkg::UNIT_W;

	// configuration
	logic [4:0]  count_q;
	logic [15:0] spacing_q;
	logic [15:0] k_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 5'd16;
			spacing_q <= 16'd256;
			k_q       <= 16'd128;
		end else if (cfg_valid) begin
			case (grb_pkg::reg_index_t'(cfg_index))
				grb_pkg::REG_GAUSSIAN_COUNT: count_q   <= cfg_data[4:0];
				grb_pkg::REG_CENTER_SPACING: spacing_q <= cfg_data;
				grb_pkg::REG_INV_TWO_SIGMA:  k_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	logic          busy_q, issuing_q;
	logic [UW-1:0] cnt_q, last_idx_q;
	logic signed [15:0] x_q;
	logic [grb_pkg::MAX_UNITS-1:0] off_vld_q;
	logic          adv, req_acc, is_load, is_sample, issue, rsp_done;
	logic [UW-1:0] last_idx;

	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = busy_q;
	assign req_acc   = req_valid && !busy_q;
	assign is_load   = req_acc && (req_data.opcode == grb_pkg::OP_LOAD);
	assign is_sample = req_acc && (req_data.opcode == grb_pkg::OP_SAMPLE);
	assign issue     = issuing_q && adv;
	assign rsp_done  = rsp_valid && !rsp_stall && rsp_data.last_of_run;

	// clamp unit count to 1..MAX_UNITS, keep last index
	always_comb begin
		if (count_q == 5'd0) begin
			last_idx = '0;
		end else if (32'(count_q) > grb_pkg::MAX_UNITS) begin
			last_idx = UW'(grb_pkg::MAX_UNITS - 1);
		end else begin
			last_idx = UW'(count_q - 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			issuing_q  <= 1'b0;
			cnt_q      <= '0;
			last_idx_q <= '0;
			off_vld_q  <= '0;
		end else begin
			if (is_load) begin
				off_vld_q[req_data.center_index] <= 1'b1;
			end
			if (is_sample) begin
				busy_q     <= 1'b1;
				issuing_q  <= 1'b1;
				cnt_q      <= '0;
				last_idx_q <= last_idx;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + UW'(1);
					if (cnt_q == last_idx_q) begin
						issuing_q <= 1'b0;
					end
				end
				if (rsp_done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// hold sample for the run
	always_ff @(posedge clk) begin
		if (is_sample) begin
			x_q <= req_data.sample_value;
		end
	end

	// offset store
	logic [15:0] ram_rd;

	grb_ram #(.WIDTH(16), .DEPTH(grb_pkg::MAX_UNITS)) u_ram (
		.clk     (clk),
		.wr_en   (is_load),
		.wr_addr (req_data.center_index),
		.wr_data (req_data.offset_value),
		.rd_en   (issue),
		.rd_addr (cnt_q),
		.rd_data (ram_rd)
	);

	// pipeline valid bits
	logic [7:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			rsp_valid <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[6:1], issuing_q};
			rsp_valid <= vld_s[7];
		end
	end

	// stage 1: RAM data arrives
	logic [UW-1:0] i_s1, i_s2, i_s3, i_s4, i_s5, i_s6, i_s7;
	logic          l_s1, l_s2, l_s3, l_s4, l_s5, l_s6, l_s7;
	logic          ov_s1;

	always_ff @(posedge clk) begin
		if (issue) begin
			i_s1  <= cnt_q;
			l_s1  <= (cnt_q == last_idx_q);
			ov_s1 <= off_vld_q[cnt_q];
		end
	end

	// form center, difference and magnitude
	logic [19:0]        step;
	logic signed [21:0] center, diff;
	logic [20:0]        mag;
	logic signed [15:0] off;

	always_comb begin
		off    = ov_s1 ? $signed(ram_rd) : 16'sd0;
		step   = 20'(i_s1) * 20'(spacing_q);
		center = $signed({2'b00, step}) + 22'(off);
		diff   = 22'(x_q) - center;
		mag    = diff[21] ? 21'(-diff) : 21'(diff);
	end

	logic [13:0] mag_s2;
	logic        big_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= mag[13:0];
			big_s2 <= |mag[20:14];
			i_s2   <= i_s1;
			l_s2   <= l_s1;
		end
	end

	// stage 2: square
	logic [27:0] sq_s3;
	logic        big_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3  <= 28'(mag_s2) * 28'(mag_s2);
			big_s3 <= big_s2;
			i_s3   <= i_s2;
			l_s3   <= l_s2;
		end
	end

	// stage 3: scale by k, take argument in Q.16
	logic [43:0] prod;
	logic [35:0] arg;

	assign prod = 44'(sq_s3) * 44'(k_q);
	assign arg  = prod[43:8];

	logic [19:0] arg_s4;
	logic        zero_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			arg_s4  <= arg[19:0];
			zero_s4 <= (big_s3 && (k_q != 16'd0)) || (arg >= grb_pkg::ARG_LIMIT);
			i_s4    <= i_s3;
			l_s4    <= l_s3;
		end
	end

	// stage 4: table product and u squared
	logic [49:0] tprod;
	logic [19:0] u;
	logic [39:0] u_sq;

	always_comb begin
		tprod = 50'(grb_pkg::exp_int(arg_s4[19:16]))
		      * 50'(grb_pkg::exp_sixteenth(arg_s4[15:12]));
		u     = {arg_s4[11:0], 8'd0};
		u_sq  = 40'(u) * 40'(u);
	end

	logic [24:0] v1_s5;
	logic [15:0] u2_s5;
	logic [19:0] u_s5;
	logic        zero_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s5   <= tprod[48:24];
			u2_s5   <= u_sq[39:24];
			u_s5    <= u;
			zero_s5 <= zero_s4;
			i_s5    <= i_s4;
			l_s5    <= l_s4;
		end
	end

	// stage 5: u cubed
	logic [35:0] u_cu;

	assign u_cu = 36'(u2_s5) * 36'(u_s5);

	logic [24:0] v1_s6;
	logic [15:0] u2_s6;
	logic [19:0] u_s6;
	logic [11:0] u3_s6;
	logic        zero_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s6   <= v1_s5;
			u2_s6   <= u2_s5;
			u_s6    <= u_s5;
			u3_s6   <= u_cu[35:24];
			zero_s6 <= zero_s5;
			i_s6    <= i_s5;
			l_s6    <= l_s5;
		end
	end

	// stage 6: polynomial 1 - u + u^2/2 - u^3/6
	logic [27:0] u3_rec;
	logic [9:0]  u3_div6;
	logic [24:0] poly;

	always_comb begin
		u3_rec  = 28'(u3_s6) * 28'(grb_pkg::RECIP6_Q18);
		u3_div6 = u3_rec[27:18];
		poly    = grb_pkg::ONE_Q24 - 25'(u_s6) + 25'(u2_s6[15:1]) - 25'(u3_div6);
	end

	logic [24:0] v1_s7, p_s7;
	logic        zero_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s7   <= v1_s6;
			p_s7    <= poly;
			zero_s7 <= zero_s6;
			i_s7    <= i_s6;
			l_s7    <= l_s6;
		end
	end

	// stage 7: final product, round, saturate into output register
	logic [49:0] vprod;
	logic [25:0] vround;
	logic [17:0] vout;
	logic [15:0] act;

	always_comb begin
		vprod  = 50'(v1_s7) * 50'(p_s7);
		vround = 26'(vprod[49:24]) + 26'd128;
		vout   = vround[25:8];
		if (zero_s7) begin
			act = 16'd0;
		end else if (vout > 18'd65535) begin
			act = 16'hFFFF;
		end else begin
			act = vout[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_data.activation  <= act;
			rsp_data.unit_index  <= 4'(i_s7);
			rsp_data.last_of_run <= l_s7;
		end
	end

endmodule
